// File: hw/rtl/fsbh_pkg.sv
// ----------------------------------------------------------------------------
// fsbh_pkg
// Shared types, status codes and helpers for the segmented binary font to hex
// text converter.
// ----------------------------------------------------------------------------
package fsbh_pkg;

  // Most results one input byte can cause: two hex digits, newline, done
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CNT_W   = 3;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CHAR    = 3'd0,
    ST_DONE    = 3'd1,
    ST_BADMARK = 3'd2,
    ST_TOOLONG = 3'd3,
    ST_BADTYPE = 3'd4,
    ST_TRUNC   = 3'd5
  } status_e;

  // Group of results produced by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    logic [MAX_RES-1:0][7:0]       chars;
    logic [MAX_RES-1:0][2:0]       stats;
  } res_bundle_t;

  // Lowercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h57 + {4'h0, nib};
  endfunction

endpackage

// File: hw/rtl/font_segment_binary_to_hex_core.sv
// ----------------------------------------------------------------------------
// font_segment_binary_to_hex_core
// Converts a segmented binary font stream to text: text segments pass
// through, binary segments become lowercase hex lines, errors are reported.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid_i, in_stall_o, in_byte_i         | in
//   output   | out_valid_o, out_stall_i, out_char_o,     | out
//            | out_status_o, out_last_o                  |
//   config   | cfg_we_i, cfg_wdata_i (file length)       | in
//
// An input byte is registered, decoded in one pass and its results loaded
// into the result register. A header byte gives no result and a text body
// byte one, so those flow at one byte per cycle while the output is not
// stalled; a binary body byte gives 2 or 3 results and a closing status
// adds one more, so a byte can hold the output channel for up to 4 results,
// handed out one per cycle unless stalled.
// Reset clears the header state, file position and file length to zero.
// Output stall holds the result register and backs up into the input stall.
// ----------------------------------------------------------------------------
module font_segment_binary_to_hex_core #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic [2:0]  out_status_o,
  output logic        out_last_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import fsbh_pkg::*;

  localparam int unsigned LCW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  // Weights of the length bytes modulo the line size
  localparam int unsigned W1 = 256 % LINE_BYTES;
  localparam int unsigned W2 = (W1 * 256) % LINE_BYTES;
  localparam int unsigned W3 = (W2 * 256) % LINE_BYTES;

  localparam logic [7:0] MARKER   = 8'd128;
  localparam logic [7:0] TYPE_TXT = 8'd1;
  localparam logic [7:0] TYPE_BIN = 8'd2;
  localparam logic [7:0] TYPE_END = 8'd3;
  localparam logic [7:0] NEWLINE  = 8'h0a;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TXT  = 2'd1;
  localparam logic [1:0] KIND_BIN  = 2'd2;

  typedef enum logic [2:0] {
    PH_MARKER,
    PH_TYPE,
    PH_LEN0,
    PH_LEN1,
    PH_LEN2,
    PH_LEN3,
    PH_BODY,
    PH_HALT
  } phase_e;

  typedef logic [LCW-1:0] mod_tab_t [256];

  // Residue of byte value times weight, modulo the line size
  function automatic mod_tab_t build_tab(input int unsigned weight);
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = LCW'((i * weight) % LINE_BYTES);
    end
    return t;
  endfunction

  localparam mod_tab_t TAB0 = build_tab(1);
  localparam mod_tab_t TAB1 = build_tab(W1);
  localparam mod_tab_t TAB2 = build_tab(W2);
  localparam mod_tab_t TAB3 = build_tab(W3);

  phase_e      phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] len_q;
  logic [LCW-1:0] modr_q, modr_d;
  logic        s1_vld_q;
  logic [7:0]  s1_byte_q;

  logic        buf_free;
  logic        s1_adv;
  res_bundle_t bund;
  logic [CNT_W-1:0] cnt_v;
  logic        halt_v;
  status_e     halt_st;

  logic [32:0] diff;
  logic        past;
  logic        at_end;
  logic [31:0] rem_full;
  logic        too_long;
  logic [LCW-1:0] mod_term;
  logic [LCW:0]   mod_sum;
  logic [LCW-1:0] mod_acc;
  logic [LCW-1:0] line_next;

  // Input register handshake
  assign s1_adv     = s1_vld_q & buf_free;
  assign in_stall_o = s1_vld_q & ~buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= in_byte_i;
    end
  end

  // Bytes left in the file and header length checks
  assign diff     = {1'b0, len_q} - {1'b0, pos_q};
  assign past     = diff[32] | (diff[31:0] == '0);
  assign at_end   = (diff[31:0] == 32'd1);
  assign rem_full = {s1_byte_q, rem_q[23:0]};
  assign too_long = (rem_full >= diff[31:0]);

  // Fold each length byte into the length modulo the line size
  always_comb begin
    case (phase_q)
      PH_LEN0: mod_term = TAB0[s1_byte_q];
      PH_LEN1: mod_term = TAB1[s1_byte_q];
      PH_LEN2: mod_term = TAB2[s1_byte_q];
      PH_LEN3: mod_term = TAB3[s1_byte_q];
      default: mod_term = '0;
    endcase
  end

  assign mod_sum   = {1'b0, modr_q} + {1'b0, mod_term};
  assign mod_acc   = (mod_sum >= (LCW + 1)'(LINE_BYTES)) ?
                     LCW'(mod_sum - (LCW + 1)'(LINE_BYTES)) : mod_sum[LCW-1:0];
  assign line_next = (modr_q == '0) ? LCW'(LINE_BYTES - 1) : modr_q - LCW'(1);

  // Decode one byte: next state and its group of results
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    modr_d  = modr_q;
    bund    = '0;
    cnt_v   = '0;
    halt_v  = 1'b0;
    halt_st = ST_DONE;

    if (phase_q != PH_HALT) begin
      if (past) begin
        // Byte beyond the configured length
        halt_v = 1'b1;
        if (phase_q == PH_MARKER) begin
          halt_st = ST_DONE;
        end else if (phase_q == PH_BODY) begin
          halt_st = ST_TOOLONG;
        end else begin
          halt_st = ST_TRUNC;
        end
      end else begin
        pos_d = pos_q + 32'd1;
        case (phase_q)
          PH_MARKER: begin
            if (s1_byte_q != MARKER) begin
              halt_v  = 1'b1;
              halt_st = ST_BADMARK;
            end else if (at_end) begin
              halt_v  = 1'b1;
              halt_st = ST_TRUNC;
            end else begin
              phase_d = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (s1_byte_q == TYPE_END) begin
              halt_v  = 1'b1;
              halt_st = ST_DONE;
            end else if (at_end) begin
              halt_v  = 1'b1;
              halt_st = ST_TRUNC;
            end else begin
              if (s1_byte_q == TYPE_TXT) begin
                kind_d = KIND_TXT;
              end else if (s1_byte_q == TYPE_BIN) begin
                kind_d = KIND_BIN;
              end else begin
                kind_d = KIND_NONE;
              end
              rem_d   = '0;
              modr_d  = '0;
              phase_d = PH_LEN0;
            end
          end
          PH_LEN0, PH_LEN1, PH_LEN2: begin
            case (phase_q)
              PH_LEN0: rem_d[7:0]   = s1_byte_q;
              PH_LEN1: rem_d[15:8]  = s1_byte_q;
              default: rem_d[23:16] = s1_byte_q;
            endcase
            modr_d = mod_acc;
            if (at_end) begin
              halt_v  = 1'b1;
              halt_st = ST_TRUNC;
            end else begin
              case (phase_q)
                PH_LEN0: phase_d = PH_LEN1;
                PH_LEN1: phase_d = PH_LEN2;
                default: phase_d = PH_LEN3;
              endcase
            end
          end
          PH_LEN3: begin
            rem_d  = rem_full;
            modr_d = mod_acc;
            if (too_long) begin
              halt_v  = 1'b1;
              halt_st = ST_TOOLONG;
            end else if (kind_q == KIND_NONE) begin
              halt_v  = 1'b1;
              halt_st = ST_BADTYPE;
            end else if (rem_full == '0) begin
              if (at_end) begin
                halt_v  = 1'b1;
                halt_st = ST_DONE;
              end else begin
                phase_d = PH_MARKER;
              end
            end else begin
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            if (kind_q == KIND_BIN) begin
              bund.chars[0] = hex_char(s1_byte_q[7:4]);
              bund.stats[0] = ST_CHAR;
              bund.chars[1] = hex_char(s1_byte_q[3:0]);
              bund.stats[1] = ST_CHAR;
              if (modr_q == '0) begin
                bund.chars[2] = NEWLINE;
                bund.stats[2] = ST_CHAR;
                cnt_v = CNT_W'(3);
              end else begin
                cnt_v = CNT_W'(2);
              end
            end else begin
              bund.chars[0] = s1_byte_q;
              bund.stats[0] = ST_CHAR;
              cnt_v = CNT_W'(1);
            end
            rem_d  = rem_q - 32'd1;
            modr_d = line_next;
            // Segment ends with this byte
            if (rem_q == 32'd1) begin
              if (at_end) begin
                halt_v  = 1'b1;
                halt_st = ST_DONE;
              end else begin
                phase_d = PH_MARKER;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // Append the closing status and halt
      if (halt_v) begin
        bund.chars[cnt_v[IDX_W-1:0]] = '0;
        bund.stats[cnt_v[IDX_W-1:0]] = halt_st;
        cnt_v   = cnt_v + CNT_W'(1);
        phase_d = PH_HALT;
      end
    end
    bund.cnt = cnt_v;
  end

  // Parser state, advanced once per decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MARKER;
      kind_q  <= KIND_NONE;
      rem_q   <= '0;
      pos_q   <= '0;
      modr_q  <= '0;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      modr_q  <= modr_d;
    end
  end

  // File length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  fsbh_res_buf u_res_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_adv),
    .bundle_i     (bund),
    .free_o       (buf_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .out_status_o (out_status_o),
    .out_last_o   (out_last_o)
  );

`ifndef SYNTHESIS
  a_body_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (rem_q != '0))
    else $error("body phase with no bytes remaining");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != ST_CHAR) |-> out_last_o)
    else $error("status result is not the last of its group");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT && !out_valid_o) |=> !out_valid_o)
    else $error("result produced after halt");
`endif

endmodule

// File: hw/rtl/fsbh_res_buf.sv
// ----------------------------------------------------------------------------
// fsbh_res_buf
// Result register: holds the results of one input byte and hands them out
// one per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module fsbh_res_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fsbh_pkg::res_bundle_t bundle_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o,
  output logic [2:0]           out_status_o,
  output logic                 out_last_o
);
  import fsbh_pkg::*;

  logic [CNT_W-1:0]        cnt_q;
  logic [IDX_W-1:0]        rd_q;
  logic [MAX_RES-1:0][7:0] chars_q;
  logic [MAX_RES-1:0][2:0] stats_q;
  logic                    out_take;

  // Present the entry at the read pointer
  assign out_valid_o  = (cnt_q != '0);
  assign out_last_o   = (cnt_q == CNT_W'(1));
  assign out_char_o   = chars_q[rd_q];
  assign out_status_o = stats_q[rd_q];
  assign out_take     = out_valid_o & ~out_stall_i;

  // Free for a new group when empty or once the last result leaves this cycle
  assign free_o = (cnt_q == '0) | (out_last_o & ~out_stall_i);

  // Track results left and the read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      rd_q  <= '0;
    end else if (out_take) begin
      cnt_q <= cnt_q - CNT_W'(1);
      rd_q  <= rd_q + IDX_W'(1);
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chars_q <= bundle_i.chars;
      stats_q <= bundle_i.stats;
    end
  end

`ifndef SYNTHESIS
  a_cnt_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {2'b00, rd_q}) <= (CNT_W + 1)'(MAX_RES))
    else $error("result count runs past the end of the group");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result group loaded over pending results");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_last_o && !load_i) |=> out_valid_o)
    else $error("results of a group lost before the last one");
`endif

endmodule

// File: tb/font_segment_binary_to_hex_core_test.sv
// ----------------------------------------------------------------------------
// font_segment_binary_to_hex_core_test
// Streams one segmented binary font file through the converter with random
// idling on both channels. A scoreboard parses the same byte stream, predicts
// every text character and status, and checks each result as it leaves.
// ----------------------------------------------------------------------------
module font_segment_binary_to_hex_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fsbh_pkg::*;

  localparam int LINE_BYTES   = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_END   = 280;

  // Header byte codes
  localparam logic [7:0] SEG_MARKER = 8'd128;
  localparam logic [7:0] SEG_TEXT   = 8'd1;
  localparam logic [7:0] SEG_BINARY = 8'd2;
  localparam logic [7:0] SEG_EOF    = 8'd3;
  localparam logic [7:0] NEWLINE    = 8'h0a;

  // Segment kinds as held by the parser
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd2;

  // Body content patterns
  localparam int PAT_RANDOM   = 0;
  localparam int PAT_EXTREMES = 1;
  localparam int PAT_DIGITS   = 2;

  typedef enum logic [3:0] {
    PH_MARKER, PH_TYPE, PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_BODY, PH_HALT
  } parse_phase_e;

  // Ways the file can finish; one is picked per run
  typedef enum int {
    END_EOF_TYPE, END_EXACT_LENGTH, END_BAD_MARKER, END_TOO_LONG, END_BAD_TYPE,
    END_TRUNC_HEADER, END_PAST_MARKER, END_PAST_HEADER, END_PAST_BODY
  } ending_e;

  typedef struct {
    logic [7:0] ch;
    status_e    st;
    logic       last;
  } text_result_t;

  // Parser of the font stream and store of the text it must produce
  class hex_text_scoreboard;
    text_result_t expected_text[$];
    text_result_t step_out[$];
    logic [31:0]  file_len;
    logic [31:0]  file_pos;
    logic [31:0]  body_left;
    logic [1:0]   seg_kind;
    parse_phase_e phase;
    int unsigned  mismatches;
    int unsigned  results_seen;

    function new();
      file_len     = '0;
      file_pos     = '0;
      body_left    = '0;
      seg_kind     = KIND_NONE;
      phase        = PH_MARKER;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void emit(logic [7:0] ch, status_e st);
      text_result_t r;
      r.ch   = ch;
      r.st   = st;
      r.last = 1'b0;
      step_out.push_back(r);
    endfunction

    function void halt_on(status_e st);
      emit(8'h00, st);
      phase = PH_HALT;
    endfunction

    function void close_segment();
      if (file_pos >= file_len) halt_on(ST_DONE);
      else phase = PH_MARKER;
    endfunction

    function logic [7:0] hex_digit(logic [3:0] nib);
      if (nib > 4'd9) return 8'h61 + 8'(nib - 4'd10);
      return 8'h30 + 8'(nib);
    endfunction

    // Advance the parser by one accepted byte and queue the text it causes
    function void note_font_byte(logic [7:0] b);
      logic at_end;
      step_out.delete();
      if (phase == PH_HALT) return;
      if (file_pos >= file_len) begin
        // byte past the end of the file
        case (phase)
          PH_MARKER: halt_on(ST_DONE);
          PH_BODY:   halt_on(ST_TOOLONG);
          default:   halt_on(ST_TRUNC);
        endcase
      end else begin
        file_pos++;
        at_end = (file_pos >= file_len);
        case (phase)
          PH_MARKER: begin
            if (b != SEG_MARKER) halt_on(ST_BADMARK);
            else if (at_end) halt_on(ST_TRUNC);
            else phase = PH_TYPE;
          end
          PH_TYPE: begin
            if (b == SEG_EOF) begin
              halt_on(ST_DONE);
            end else if (at_end) begin
              halt_on(ST_TRUNC);
            end else begin
              seg_kind  = (b == SEG_TEXT || b == SEG_BINARY) ? b[1:0] : KIND_NONE;
              body_left = '0;
              phase     = PH_LEN0;
            end
          end
          PH_LEN0, PH_LEN1, PH_LEN2: begin
            case (phase)
              PH_LEN0: body_left[7:0]   = b;
              PH_LEN1: body_left[15:8]  = b;
              default: body_left[23:16] = b;
            endcase
            if (at_end) halt_on(ST_TRUNC);
            else phase = parse_phase_e'(phase + 1);
          end
          PH_LEN3: begin
            body_left[31:24] = b;
            // length check comes before the type check
            if (body_left > file_len - file_pos) halt_on(ST_TOOLONG);
            else if (seg_kind == KIND_NONE) halt_on(ST_BADTYPE);
            else if (body_left == 0) close_segment();
            else phase = PH_BODY;
          end
          default: begin
            if (seg_kind == KIND_BINARY) begin
              emit(hex_digit(b[7:4]), ST_CHAR);
              emit(hex_digit(b[3:0]), ST_CHAR);
              if (body_left % LINE_BYTES == 0) emit(NEWLINE, ST_CHAR);
            end else begin
              emit(b, ST_CHAR);
            end
            if (body_left > 0) body_left--;
            if (body_left == 0) close_segment();
          end
        endcase
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_text.push_back(step_out[i]);
    endfunction

    // Compare one accepted result with the oldest pending one
    function void check_text_out(logic [7:0] ch, logic [2:0] st, logic lst);
      text_result_t want;
      results_seen++;
      if (expected_text.size() == 0) begin
        mismatches++;
        $error("unexpected result: out_char %h status %0d last %0b", ch, st, lst);
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        mismatches++;
        $error("out_char: expected %h, actual %h", want.ch, ch);
      end
      if (st !== want.st) begin
        mismatches++;
        $error("status: expected %0d, actual %0d", want.st, st);
      end
      if (lst !== want.last) begin
        mismatches++;
        $error("last: expected %0b, actual %0b", want.last, lst);
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_char_o;
  logic [2:0]  out_status_o;
  logic        out_last_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  hex_text_scoreboard sb;
  bit          idle_on     = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  ending_e     ending;

  font_segment_binary_to_hex_core #(
    .LINE_BYTES(LINE_BYTES)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .out_status_o(out_status_o),
    .out_last_o  (out_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the output in random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 13);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_text_out(out_char_o, out_status_o, out_last_o);
    end
  end

  // Offer one byte, hold it until accepted; returns on a falling edge, valid high
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_font_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every pending result is out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_text.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_file_length(input logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.file_len = value;
  endtask

  // Send the first count bytes of a segment header
  task automatic send_header(input logic [7:0] kind, input logic [31:0] len,
                             input int count);
    logic [7:0] hdr [6];
    hdr[0] = SEG_MARKER;
    hdr[1] = kind;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    hdr[4] = len[23:16];
    hdr[5] = len[31:24];
    for (int i = 0; i < count; i++) send_byte(hdr[i]);
  endtask

  task automatic send_segment(input logic [7:0] kind, input int unsigned len,
                              input int pattern);
    logic [7:0] b;
    send_header(kind, len, 6);
    for (int i = 0; i < len; i++) begin
      case (pattern)
        PAT_EXTREMES: b = i[0] ? 8'hff : 8'h00;
        PAT_DIGITS:   b = 8'(((2 * i) << 4) | (2 * i + 1));
        default:      b = 8'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  // Finish the file along one randomly chosen path
  task automatic run_ending();
    int unsigned len;
    int unsigned k;
    logic [7:0]  b;
    logic [7:0]  kind;
    kind = $urandom_range(0, 1) ? SEG_BINARY : SEG_TEXT;
    case (ending)
      END_EOF_TYPE: begin
        send_header(SEG_EOF, '0, 2);
      end
      END_EXACT_LENGTH: begin
        len = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
        write_file_length(sb.file_pos + 6 + len);
        send_segment(kind, len, PAT_RANDOM);
      end
      END_BAD_MARKER: begin
        b = 8'($urandom_range(0, 254));
        if (b >= SEG_MARKER) b++;
        send_byte(b);
      end
      END_TOO_LONG: begin
        len = $urandom_range(0, 20);
        write_file_length(sb.file_pos + 6 + len);
        b = 8'($urandom_range(0, 254));
        if (b >= SEG_EOF) b++;
        send_header(b, $urandom_range(0, 1) ? 32'hFFFF_FFFF : len + 1 + $urandom_range(0, 999),
                    6);
      end
      END_BAD_TYPE: begin
        b = 8'($urandom_range(0, 252));
        if (b >= SEG_TEXT) b += 3;
        send_header(b, $urandom_range(0, 50), 6);
      end
      END_TRUNC_HEADER: begin
        k = $urandom_range(1, 5);
        write_file_length(sb.file_pos + k);
        send_header(kind, $urandom, k);
      end
      END_PAST_MARKER: begin
        write_file_length($urandom_range(0, 1) ? 32'd0 : sb.file_pos);
        send_byte(8'($urandom));
      end
      END_PAST_HEADER: begin
        send_header(kind, $urandom_range(0, 100), $urandom_range(1, 5));
        write_file_length(sb.file_pos);
        send_byte(8'($urandom));
      end
      default: begin
        len = $urandom_range(2, 10);
        send_header(kind, len, 6);
        repeat ($urandom_range(1, len - 1)) send_byte(8'($urandom));
        write_file_length(sb.file_pos);
        send_byte(8'($urandom));
      end
    endcase
  endtask

  initial begin
    int unsigned len;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme bytes in text, empty binary body, every hex digit
    write_file_length(32'hFFFF_FFFF);
    send_segment(SEG_TEXT, 2, PAT_EXTREMES);
    send_segment(SEG_BINARY, 0, PAT_RANDOM);
    send_segment(SEG_BINARY, 8, PAT_DIGITS);

    // Random well-formed segments, new file length and idling per phase
    while (items_sent < RANDOM_END) begin
      write_file_length($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF :
                        $urandom_range(32'hFFFF_FFFF, sb.file_pos + 4096));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4)) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(60, 66);
          1, 2:    len = $urandom_range(28, 36);
          default: len = $urandom_range(0, 12);
        endcase
        send_segment($urandom_range(0, 1) ? SEG_BINARY : SEG_TEXT, len, PAT_RANDOM);
      end
    end

    // Final stretch without idling: end the file, then bytes that are swallowed
    idle_on = 1'b0;
    ending  = ending_e'($urandom_range(0, 8));
    run_ending();
    repeat (12) send_byte(8'($urandom));
    drain();
    repeat (20) @(negedge clk_i);

    $display("Sent %0d font bytes, checked %0d text results, file finished by %s",
             items_sent, sb.results_seen, ending.name());
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fsbh_pkg.sv
hw/rtl/fsbh_res_buf.sv
hw/rtl/font_segment_binary_to_hex_core.sv
tb/font_segment_binary_to_hex_core_test.sv
